/* hdl/audio_min_max_rms_summary_macros.svh */
// Assertion macros shared by the audio summary checker.
// No dependencies.
`ifndef AUDIO_MIN_MAX_RMS_SUMMARY_MACROS_SVH
`define AUDIO_MIN_MAX_RMS_SUMMARY_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define AMS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define AMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

/* hdl/ams_pkg.sv */
// Types and constants for the audio min/max/RMS summary block.
// No dependencies.
package ams_pkg;
  localparam int unsigned SampleW = 16;
  localparam int unsigned WinLog = 8;
  localparam logic [1:0] LevelShort = 2'd0;
  localparam logic [1:0] LevelLong  = 2'd1;
  localparam logic [1:0] LevelBlock = 2'd2;

  // Datapath operation selected by the controller.
  typedef enum logic [2:0] {
    OpNone, OpSample, OpCloseShort, OpCloseLong, OpCloseBlock
  } op_e;

  // The eob bit tells a window close that a block summary still follows.
  typedef struct packed {
    op_e  op;
    logic eob;
    logic start;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic short_full;
    logic long_full;
    logic short_any;
    logic long_any;
    logic size_ok;
  } stat_t;
endpackage

/* hdl/ams_if.sv */
// Valid/ready channel interfaces for the summary block.
// No dependencies.
interface ams_in_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  sample;
  logic                end_of_block;
  modport source (output valid, sample, end_of_block, input ready);
  modport sink (input valid, sample, end_of_block, output ready);
endinterface

interface ams_out_if;
  logic                valid;
  logic                ready;
  logic [1:0]          level;
  logic signed [15:0]  min_value;
  logic signed [15:0]  max_value;
  logic [15:0]         rms_value;
  logic                last_of_run;
  modport source (output valid, level, min_value, max_value, rms_value, last_of_run,
                  input ready);
  modport sink (input valid, level, min_value, max_value, rms_value, last_of_run,
                output ready);
endinterface

/* hdl/ams_ctrl.sv */
// Controller for the summary block: sequences sample update and window closes.
// Depends on ams_pkg.
module ams_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_eob_i,
  output logic           in_ready_o,
  input  logic           out_busy_i,
  input  ams_pkg::stat_t stat_i,
  output ams_pkg::cmd_t  cmd_o
);
  import ams_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StWait  = 3'd1;
  localparam logic [2:0] StShort = 3'd2;
  localparam logic [2:0] StLong  = 3'd3;
  localparam logic [2:0] StBlock = 3'd4;
  localparam logic [2:0] StChk   = 3'd5;

  logic [2:0] state_q, state_d;
  logic       eob_q, eob_d;
  logic       flush_q, flush_d;

  // A unit operation may start only when the datapath and output are free,
  // including the cycle in which a finished result moves to the output.
  logic free;
  assign free = !stat_i.busy && !stat_i.done && !out_busy_i;

  always_comb begin
    state_d = state_q;
    eob_d = eob_q;
    flush_d = flush_q;
    cmd_o = '{op: OpNone, eob: 1'b0, start: 1'b0};
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          eob_d = in_eob_i;
          flush_d = 1'b0;
          cmd_o = '{op: OpSample, eob: in_eob_i, start: 1'b1};
          state_d = StWait;
        end
      end
      StWait: state_d = StChk;
      StChk: begin
        if (stat_i.short_full || (flush_q && stat_i.short_any)) state_d = StShort;
        else if (stat_i.long_full || (flush_q && stat_i.long_any)) state_d = StLong;
        else if (eob_q && !flush_q) flush_d = 1'b1;
        else if (eob_q) state_d = StBlock;
        else state_d = StIdle;
      end
      StShort: if (free) begin
        cmd_o = '{op: OpCloseShort, eob: eob_q, start: 1'b1};
        state_d = StWait;
      end
      StLong: if (free) begin
        cmd_o = '{op: OpCloseLong, eob: eob_q, start: 1'b1};
        state_d = StWait;
      end
      StBlock: if (free) begin
        cmd_o = '{op: OpCloseBlock, eob: eob_q, start: 1'b1};
        state_d = StWait;
        eob_d = 1'b0;
        flush_d = 1'b0;
      end
      default: state_d = StIdle;
    endcase
  end

  // The check state waits until the datapath finished any root in flight.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      eob_q <= 1'b0;
      flush_q <= 1'b0;
    end else begin
      if (state_q == StChk && stat_i.busy) state_q <= StChk;
      else state_q <= state_d;
      eob_q <= eob_d;
      flush_q <= flush_d;
    end
  end
endmodule

/* hdl/ams_dp.sv */
// Datapath for the summary block: accumulators, divider and square root unit.
// Depends on ams_pkg.
module ams_dp #(
  parameter int unsigned MaxBlockSamples = 1048576
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ams_pkg::cmd_t      cmd_i,
  input  logic signed [15:0] sample_i,
  output ams_pkg::stat_t     stat_o,
  // Result handed to the output register.
  output logic               res_valid_o,
  output logic [1:0]         res_level_o,
  output logic signed [15:0] res_min_o,
  output logic signed [15:0] res_max_o,
  output logic [15:0]        res_rms_o,
  output logic               res_last_o
);
  import ams_pkg::*;

  localparam int unsigned TotW = $clog2(MaxBlockSamples + 1) + 1;

  logic [8:0]         s_cnt_q, l_cnt_q;
  logic [TotW-1:0]    tot_q;
  logic [16:0]        b_cnt_q;
  logic signed [15:0] s_min_q, s_max_q, l_min_q, l_max_q, b_min_q, b_max_q;
  logic [38:0]        s_sum_q, l_sum_q;
  logic [46:0]        b_sum_q;

  // Sequential divide then square root engine.
  localparam logic [1:0] EIdle = 2'd0, EDiv = 2'd1, ESqrt = 2'd2;
  logic [1:0]   eph_q;
  logic [46:0]  num_q;
  logic [16:0]  den_q;
  logic [46:0]  quo_q;
  logic [16:0]  rem_q;
  logic [5:0]   step_q;
  logic [39:0]  rad_q;
  logic [39:0]  root_q;
  logic [39:0]  bit_q;
  logic [1:0]   lvl_q;
  logic signed [15:0] rmin_q, rmax_q;
  logic         last_q;
  logic         res_valid_q;

  logic signed [31:0] sq;
  assign sq = sample_i * sample_i;

  logic [17:0] rem_sh;
  assign rem_sh = {rem_q, num_q[46]};

  logic [39:0] trial;
  assign trial = root_q + bit_q;

  logic in_range;
  assign in_range = tot_q < TotW'(MaxBlockSamples);

  assign stat_o.busy = eph_q != EIdle;
  assign stat_o.done = res_valid_q;
  assign stat_o.short_full = s_cnt_q[8];
  assign stat_o.long_full = l_cnt_q[8];
  assign stat_o.short_any = s_cnt_q != '0;
  assign stat_o.long_any = l_cnt_q != '0;
  assign stat_o.size_ok = in_range;

  assign res_valid_o = res_valid_q;
  assign res_level_o = lvl_q;
  assign res_min_o = rmin_q;
  assign res_max_o = rmax_q;
  assign res_rms_o = root_q[15:0];
  assign res_last_o = last_q;

  // Control registers of the engine.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eph_q <= EIdle;
      res_valid_q <= 1'b0;
      s_cnt_q <= '0;
      l_cnt_q <= '0;
      b_cnt_q <= '0;
      tot_q <= '0;
    end else begin
      res_valid_q <= 1'b0;
      if (cmd_i.start) begin
        unique case (cmd_i.op)
          OpSample: if (in_range) begin
            s_cnt_q <= s_cnt_q + 9'd1;
            tot_q <= tot_q + TotW'(1);
          end
          OpCloseShort: begin
            eph_q <= EDiv;
            s_cnt_q <= '0;
          end
          OpCloseLong: begin
            eph_q <= EDiv;
            l_cnt_q <= '0;
          end
          OpCloseBlock: begin
            eph_q <= (b_cnt_q == '0) ? EIdle : EDiv;
            res_valid_q <= (b_cnt_q == '0);
            s_cnt_q <= '0;
            l_cnt_q <= '0;
            b_cnt_q <= '0;
            tot_q <= '0;
          end
          default: ;
        endcase
      end else if (eph_q == EDiv && step_q == 6'd46) begin
        eph_q <= ESqrt;
      end else if (eph_q == ESqrt && bit_q == '0) begin
        eph_q <= EIdle;
        res_valid_q <= 1'b1;
        unique case (lvl_q)
          LevelShort: l_cnt_q <= l_cnt_q + 9'd1;
          LevelLong: b_cnt_q <= b_cnt_q + 17'd1;
          default: ;
        endcase
      end
    end
  end

  // Payload registers: accumulators and engine data.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      step_q <= '0;
      rem_q <= '0;
      root_q <= '0;
      unique case (cmd_i.op)
        OpSample: if (in_range) begin
          if (s_cnt_q == '0) begin
            s_min_q <= sample_i;
            s_max_q <= sample_i;
            s_sum_q <= 39'(unsigned'(sq));
          end else begin
            if (sample_i < s_min_q) s_min_q <= sample_i;
            if (sample_i > s_max_q) s_max_q <= sample_i;
            s_sum_q <= s_sum_q + 39'(unsigned'(sq));
          end
        end
        OpCloseShort: begin
          num_q <= 47'(s_sum_q);
          den_q <= 17'(s_cnt_q);
          lvl_q <= LevelShort;
          rmin_q <= s_min_q;
          rmax_q <= s_max_q;
          // Last of the run unless a long close or the block summary follows.
          last_q <= !cmd_i.eob && (l_cnt_q != 9'd255);
        end
        OpCloseLong: begin
          num_q <= 47'(l_sum_q >> WinLog);
          den_q <= 17'd1;
          lvl_q <= LevelLong;
          rmin_q <= (!l_cnt_q[8] && l_min_q > 16'sd0) ? 16'sd0 : l_min_q;
          rmax_q <= (!l_cnt_q[8] && l_max_q < 16'sd0) ? 16'sd0 : l_max_q;
          last_q <= !cmd_i.eob;
        end
        OpCloseBlock: begin
          num_q <= b_sum_q;
          den_q <= b_cnt_q;
          lvl_q <= LevelBlock;
          rmin_q <= (b_cnt_q == '0) ? 16'sd0 : b_min_q;
          rmax_q <= (b_cnt_q == '0) ? 16'sd0 : b_max_q;
          last_q <= 1'b1;
        end
        default: ;
      endcase
    end else if (eph_q == EDiv) begin
      // Restoring division, one quotient bit per cycle.
      num_q <= {num_q[45:0], 1'b0};
      if (rem_sh >= {1'b0, den_q}) begin
        rem_q <= 17'(rem_sh - {1'b0, den_q});
        quo_q <= {quo_q[45:0], 1'b1};
      end else begin
        rem_q <= rem_sh[16:0];
        quo_q <= {quo_q[45:0], 1'b0};
      end
      step_q <= step_q + 6'd1;
      if (step_q == 6'd46) begin
        bit_q <= 40'd1 << 38;
        root_q <= '0;
      end
    end else if (eph_q == ESqrt) begin
      // Quotient fits 39 bits; one root bit per cycle.
      if (step_q == 6'd47) begin
        rad_q <= 40'(quo_q);
        step_q <= 6'd48;
      end else if (bit_q != '0) begin
        if (rad_q >= trial) begin
          rad_q <= rad_q - trial;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
    end
    if (eph_q == EDiv && step_q == 6'd46) begin
      step_q <= 6'd47;
    end
    // Fold a finished root into the next summary level.
    if (eph_q == ESqrt && bit_q == '0) begin
      if (lvl_q == LevelShort) begin
        if (l_cnt_q == '0) begin
          l_min_q <= rmin_q;
          l_max_q <= rmax_q;
          l_sum_q <= 39'(root_q[15:0] * root_q[15:0]);
        end else begin
          if (rmin_q < l_min_q) l_min_q <= rmin_q;
          if (rmax_q > l_max_q) l_max_q <= rmax_q;
          l_sum_q <= l_sum_q + 39'(root_q[15:0] * root_q[15:0]);
        end
      end else if (lvl_q == LevelLong) begin
        if (b_cnt_q == '0) begin
          b_min_q <= rmin_q;
          b_max_q <= rmax_q;
          b_sum_q <= 47'(root_q[15:0] * root_q[15:0]);
        end else begin
          if (rmin_q < b_min_q) b_min_q <= rmin_q;
          if (rmax_q > b_max_q) b_max_q <= rmax_q;
          b_sum_q <= b_sum_q + 47'(root_q[15:0] * root_q[15:0]);
        end
      end
    end
  end
endmodule

/* hdl/audio_min_max_rms_summary.sv */
// Top level of the audio min/max/RMS summary block.
// Depends on ams_pkg, ams_if, ams_ctrl and ams_dp.
// Each window close runs a restoring divider and then a square root in one
// shared unit (an empty block summary skips both). A new sample is accepted
// only after every close that the last one started has finished (up to three
// results at block end). A finished result waits in an output register.
module audio_min_max_rms_summary #(
  parameter int unsigned MaxBlockSamples = 1048576
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ams_in_if.sink       in_if,
  ams_out_if.source    out_if
);
  import ams_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic               res_valid, res_last;
  logic [1:0]         res_level;
  logic signed [15:0] res_min, res_max;
  logic [15:0]        res_rms;
  logic               out_valid_q;

  ams_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_eob_i(in_if.end_of_block), .in_ready_o(in_if.ready),
    .out_busy_i(out_valid_q), .stat_i(stat), .cmd_o(cmd)
  );

  ams_dp #(.MaxBlockSamples(MaxBlockSamples)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sample_i(in_if.sample), .stat_o(stat),
    .res_valid_o(res_valid), .res_level_o(res_level), .res_min_o(res_min),
    .res_max_o(res_max), .res_rms_o(res_rms), .res_last_o(res_last)
  );

  // Output register holds one beat until taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_if.level <= res_level;
      out_if.min_value <= res_min;
      out_if.max_value <= res_max;
      out_if.rms_value <= res_rms;
      out_if.last_of_run <= res_last;
    end
  end

  assign out_if.valid = out_valid_q;
endmodule

/* hdl/ams_checker.sv */
// Port-level checker for the summary block, bound to the top level.
// Depends on ams_pkg and the assertion macros header.
`include "audio_min_max_rms_summary_macros.svh"
module ams_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  level,
  input logic        last_of_run,
  input logic [15:0] rms_value
);
  import ams_pkg::*;

  `AMS_ASSERT_IMPL(a_level, clk_i, rst_ni, out_valid, level <= LevelBlock, "bad level")
  `AMS_ASSERT_IMPL(a_block_last, clk_i, rst_ni, out_valid && level == LevelBlock, last_of_run, "block beat not last")
  `AMS_ASSERT_IMPL(a_rms, clk_i, rst_ni, out_valid, rms_value <= 16'd32768, "rms out of range")
  `AMS_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid && $stable(level), "beat dropped")
  `AMS_ASSERT_NEXT(a_in_gap, clk_i, rst_ni, in_valid && in_ready, !in_ready, "input accepted back to back")
endmodule

bind audio_min_max_rms_summary ams_checker u_ams_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready), .level(out_if.level),
  .last_of_run(out_if.last_of_run), .rms_value(out_if.rms_value)
);
